// ===== rtl/wildcard_name_matcher_defines.svh =====
// Assertion macros for the wildcard name matcher
`ifndef WILDCARD_NAME_MATCHER_DEFINES_SVH
`define WILDCARD_NAME_MATCHER_DEFINES_SVH
`ifndef SYNTHESIS
`define WNM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WNM_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `WNM_ASSERT(label, clk, rst, !(cond), msg)
`else
`define WNM_ASSERT(label, clk, rst, prop, msg)
`define WNM_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== rtl/wnm_pkg.sv =====
// Shared types and character codes for the wildcard name matcher
package wnm_pkg;

   localparam logic [7:0] CH_STAR     = 8'h2A;
   localparam logic [7:0] CH_QUESTION = 8'h3F;
   localparam logic [7:0] CH_SLASH    = 8'h2F;

   localparam logic KIND_PATTERN = 1'b0;
   localparam logic KIND_NAME    = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SLASH    = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic       kind;
      logic [7:0] ch;
      logic       last;
   } wnm_item_type;

   typedef struct packed {
      logic       pat_fire;
      logic       name_fire;
      logic       last;
      logic [7:0] ch;
   } wnm_step_type;

endpackage

// ===== rtl/wnm_pattern_store.sv =====
// Pattern character store with load pointer, pattern length and fault status
module wnm_pattern_store import wnm_pkg::*; #(
   parameter int PATTERN_MAX = 256,
   localparam int LEN_W = $clog2(PATTERN_MAX + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wnm_step_type           step,
   output logic [PATTERN_MAX-1:0] star_now,
   output logic [PATTERN_MAX-1:0] star_next,
   output logic [PATTERN_MAX-1:0] lit_hit,
   output logic [LEN_W-1:0]       len,
   output logic [LEN_W-1:0]       len_next,
   output logic [1:0]             status,
   output logic [1:0]             status_next
);

   logic [7:0]       char_ff [PATTERN_MAX];
   logic [7:0]       char_in [PATTERN_MAX];
   logic [LEN_W-1:0] lp_ff, lp_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [1:0]       fault_ff, fault_in;
   logic             room;
   logic             write_en;
   logic [LEN_W-1:0] lp_after;
   logic [1:0]       fault_new;

   always_comb begin
      room     = lp_ff < LEN_W'(PATTERN_MAX);
      write_en = step.pat_fire && room;
      lp_after = room ? lp_ff + LEN_W'(1) : lp_ff;
      fault_new = (lp_ff == '0) ? STATUS_OK : fault_ff;
      if (step.ch == CH_SLASH) begin
         fault_new = STATUS_SLASH;
      end
      if (!room && fault_new == STATUS_OK) begin
         fault_new = STATUS_OVERFLOW;
      end
      fault_in = fault_ff;
      lp_in    = lp_ff;
      len_in   = len_ff;
      if (step.pat_fire) begin
         fault_in = fault_new;
         if (step.last) begin
            len_in = lp_after;
            lp_in  = '0;
         end else begin
            lp_in = lp_after;
         end
      end
   end

   always_comb begin
      for (int p = 0; p < PATTERN_MAX; p++) begin
         char_in[p] = char_ff[p];
         if (write_en && lp_ff == LEN_W'(p)) begin
            char_in[p] = step.ch;
         end
         star_now[p]  = char_ff[p] == CH_STAR;
         star_next[p] = char_in[p] == CH_STAR;
         lit_hit[p]   = char_ff[p] == CH_QUESTION || char_ff[p] == step.ch;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_ff    <= '0;
         len_ff   <= '0;
         fault_ff <= STATUS_OK;
      end else begin
         lp_ff    <= lp_in;
         len_ff   <= len_in;
         fault_ff <= fault_in;
      end
   end

   assign len         = len_ff;
   assign len_next    = len_in;
   assign status      = fault_ff;
   assign status_next = fault_in;

endmodule

// ===== rtl/wnm_position_set.sv =====
// Bit-parallel set of reachable pattern positions with star closure
module wnm_position_set import wnm_pkg::*; #(
   parameter int PATTERN_MAX = 256,
   localparam int LEN_W = $clog2(PATTERN_MAX + 1),
   localparam int SET_W = PATTERN_MAX + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wnm_step_type           step,
   input  logic [PATTERN_MAX-1:0] star_now,
   input  logic [PATTERN_MAX-1:0] star_next,
   input  logic [PATTERN_MAX-1:0] lit_hit,
   input  logic [LEN_W-1:0]       len,
   input  logic [LEN_W-1:0]       len_next,
   output logic                   hit
);

   localparam logic [SET_W-1:0] START = SET_W'(1);

   logic [SET_W-1:0]       raw_ff, raw_in;
   logic [SET_W-1:0]       closed_ff, closed_in;
   logic [PATTERN_MAX-1:0] below_now, below_next;
   logic [SET_W-1:0]       m_now, m_next;
   logic [SET_W-1:0]       step_set, raw_sel, closed_a, closed_0;
   logic [PATTERN_MAX-1:0] act_lo;
   logic                   not_slash;

   // carry chain: fill upward through runs of stars from each reached star
   function automatic logic [SET_W-1:0] close_stars(input logic [SET_W-1:0] s,
                                                    input logic [SET_W-1:0] m);
      return s | (((s & m) + m) ^ m);
   endfunction

   always_comb begin
      for (int p = 0; p < PATTERN_MAX; p++) begin
         below_now[p]  = LEN_W'(p) < len;
         below_next[p] = LEN_W'(p) < len_next;
      end
   end

   always_comb begin
      m_now     = {1'b0, star_now & below_now};
      m_next    = {1'b0, star_next & below_next};
      not_slash = step.ch != CH_SLASH;
      act_lo    = closed_ff[PATTERN_MAX-1:0] & below_now;
      step_set  = {1'b0, act_lo & star_now & {PATTERN_MAX{not_slash}}}
                | {act_lo & ~star_now & lit_hit, 1'b0};
      if (step.name_fire) begin
         raw_sel = step_set;
      end else if (step.pat_fire && step.last) begin
         raw_sel = START;
      end else begin
         raw_sel = raw_ff;
      end
      closed_a = close_stars(raw_sel, m_next);
      closed_0 = close_stars(START, m_next);
      if (step.name_fire && step.last) begin
         raw_in    = START;
         closed_in = closed_0;
      end else begin
         raw_in    = raw_sel;
         closed_in = closed_a;
      end
      hit = closed_a[len];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff    <= START;
         closed_ff <= START;
      end else begin
         raw_ff    <= raw_in;
         closed_ff <= closed_in;
      end
   end

endmodule

// ===== rtl/wildcard_name_matcher.sv =====
// Top level of the wildcard name matcher: input stage, pattern store, position set, result
// One item per cycle unless a result waits unaccepted; position set steps once per character.
// An item's result is registered in the response register after the input stage fires it.
// The per-cycle path is the parallel character compare followed by the star-closure carry chain.
// Reset clears the pipeline, pattern length, load pointer and status, and sets position zero.
// Pattern store contents are undefined until loaded; no clearing pass is run.
`include "wildcard_name_matcher_defines.svh"
module wildcard_name_matcher import wnm_pkg::*; #(
   parameter int PATTERN_MAX = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_ch,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_result_kind,
   output logic       rsp_matched,
   output logic [1:0] rsp_pattern_status
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);

   logic                   in_v_ff, in_v_in;
   wnm_item_type           item_ff, item_in;
   logic                   rsp_v_ff, rsp_v_in;
   logic                   kind_ff, kind_in;
   logic                   matched_ff, matched_in;
   logic [1:0]             status_ff, status_in;
   logic                   fire;
   wnm_step_type           step;
   logic [PATTERN_MAX-1:0] star_now, star_next, lit_hit;
   logic [LEN_W-1:0]       len, len_next;
   logic [1:0]             status, status_next;
   logic                   hit;

   always_comb begin
      fire      = in_v_ff && (!rsp_v_ff || rsp_ready);
      req_ready = !in_v_ff || fire;

      step.pat_fire  = fire && item_ff.kind == KIND_PATTERN;
      step.name_fire = fire && item_ff.kind == KIND_NAME;
      step.last      = item_ff.last;
      step.ch        = item_ff.ch;

      in_v_in = in_v_ff;
      item_in = item_ff;
      if (req_ready) begin
         in_v_in = req_valid;
         item_in = '{kind: req_kind, ch: req_ch, last: req_last};
      end

      rsp_v_in   = rsp_v_ff;
      kind_in    = kind_ff;
      matched_in = matched_ff;
      status_in  = status_ff;
      if (fire) begin
         rsp_v_in = item_ff.last;
         if (item_ff.last) begin
            kind_in    = item_ff.kind;
            matched_in = item_ff.kind == KIND_NAME && hit && status == STATUS_OK;
            status_in  = (item_ff.kind == KIND_PATTERN) ? status_next : status;
         end
      end else if (rsp_ready) begin
         rsp_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      kind_ff    <= kind_in;
      matched_ff <= matched_in;
      status_ff  <= status_in;
   end

   wnm_pattern_store #(.PATTERN_MAX(PATTERN_MAX)) u_store (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .star_now    (star_now),
      .star_next   (star_next),
      .lit_hit     (lit_hit),
      .len         (len),
      .len_next    (len_next),
      .status      (status),
      .status_next (status_next)
   );

   wnm_position_set #(.PATTERN_MAX(PATTERN_MAX)) u_posset (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .star_now  (star_now),
      .star_next (star_next),
      .lit_hit   (lit_hit),
      .len       (len),
      .len_next  (len_next),
      .hit       (hit)
   );

   assign rsp_valid          = rsp_v_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_matched        = matched_ff;
   assign rsp_pattern_status = status_ff;

   `WNM_ASSERT(a_last_gives_result, clock, reset, fire && item_ff.last |=> rsp_v_ff, "final item gave no result")
   `WNM_ASSERT(a_stage_holds, clock, reset, in_v_ff && !fire |=> in_v_ff && $stable(item_ff), "input stage lost its item")
   `WNM_ASSERT_NEVER(a_match_clean, clock, reset, rsp_v_ff && matched_ff && (status_ff != STATUS_OK || kind_ff != KIND_NAME), "match reported under fault or on load status")

endmodule

// ===== tb/wildcard_name_matcher_tb.sv =====
// Self-checking testbench for the wildcard name matcher: streamed patterns and names
module wildcard_name_matcher_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wnm_pkg::*;

   localparam int STORE_DEPTH  = 256;
   localparam int RANDOM_ITEMS = 1100;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 8;

   typedef logic [7:0] char_q_type[$];

   typedef struct {
      logic       result_kind;
      logic       matched;
      logic [1:0] status;
   } verdict_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_kind = KIND_PATTERN;
   logic [7:0] req_ch = 8'h00;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_result_kind;
   logic       rsp_matched;
   logic [1:0] rsp_pattern_status;

   verdict_type verdict_q[$];
   logic [7:0]  pat_chars[STORE_DEPTH];
   int          pat_len;
   int          load_ptr;
   logic [1:0]  pat_fault;
   bit          reach[STORE_DEPTH + 1];
   int          errors = 0;
   int          items_sent = 0;
   int          cycle_count = 0;
   bit          calm = 1'b0;

   wildcard_name_matcher dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_ch             (req_ch),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_matched        (rsp_matched),
      .rsp_pattern_status (rsp_pattern_status)
   );

   always #4 clock = ~clock;

   function automatic void restart_positions();
      foreach (reach[i]) reach[i] = 1'b0;
      reach[0] = 1'b1;
   endfunction

   // a star may match nothing, so carry its position onwards
   function automatic void close_stars();
      for (int p = 0; p < pat_len; p++) begin
         if (reach[p] && pat_chars[p] == CH_STAR) reach[p + 1] = 1'b1;
      end
   endfunction

   function automatic void step_matcher(logic kind, logic [7:0] ch, logic last);
      bit          nxt[STORE_DEPTH + 1];
      verdict_type v;
      if (kind == KIND_PATTERN) begin
         if (load_ptr == 0) pat_fault = STATUS_OK;
         if (ch == CH_SLASH) pat_fault = STATUS_SLASH;
         if (load_ptr < STORE_DEPTH) begin
            pat_chars[load_ptr] = ch;
            load_ptr++;
         end else if (pat_fault == STATUS_OK) begin
            pat_fault = STATUS_OVERFLOW;
         end
         if (last) begin
            pat_len  = load_ptr;
            load_ptr = 0;
            restart_positions();
            v.result_kind = KIND_PATTERN;
            v.matched     = 1'b0;
            v.status      = pat_fault;
            verdict_q.push_back(v);
         end
      end else begin
         close_stars();
         foreach (nxt[i]) nxt[i] = 1'b0;
         for (int p = 0; p < pat_len; p++) begin
            if (reach[p]) begin
               if (pat_chars[p] == CH_STAR) begin
                  if (ch != CH_SLASH) nxt[p] = 1'b1;
               end else if (pat_chars[p] == CH_QUESTION || pat_chars[p] == ch) begin
                  nxt[p + 1] = 1'b1;
               end
            end
         end
         reach = nxt;
         if (last) begin
            close_stars();
            v.result_kind = KIND_NAME;
            v.matched     = reach[pat_len] && pat_fault == STATUS_OK;
            v.status      = pat_fault;
            verdict_q.push_back(v);
            restart_positions();
         end
      end
   endfunction

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic char_q_type chars(string s);
      char_q_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   function automatic logic [7:0] pick_pattern_char(bit allow_slash);
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return CH_STAR;
      if (r < 45) return CH_QUESTION;
      if (r < 90) return 8'(97 + $urandom_range(0, 2));
      if (r < 97 || !allow_slash) return 8'($urandom_range(0, 255));
      return CH_SLASH;
   endfunction

   function automatic logic [7:0] pick_name_char(bit allow_slash);
      int         r;
      logic [7:0] c;
      r = $urandom_range(0, 9);
      if (r < 8) c = 8'(97 + $urandom_range(0, 2));
      else if (r < 9) c = CH_SLASH;
      else c = 8'($urandom_range(0, 255));
      if (!allow_slash && c == CH_SLASH) c = "a";
      return c;
   endfunction

   function automatic char_q_type derive_name(char_q_type pat);
      char_q_type nm;
      foreach (pat[i]) begin
         if (pat[i] == CH_STAR) begin
            repeat ($urandom_range(0, 3)) nm.push_back(pick_name_char(1'b0));
         end else if (pat[i] == CH_QUESTION) begin
            nm.push_back(pick_name_char(1'b1));
         end else begin
            nm.push_back(pat[i]);
         end
      end
      if (nm.size() > 0 && $urandom_range(0, 3) == 0) begin
         nm[$urandom_range(0, nm.size() - 1)] = pick_name_char(1'b1);
      end
      if (nm.size() == 0) nm.push_back(pick_name_char(1'b1));
      return nm;
   endfunction

   function automatic char_q_type random_name();
      char_q_type nm;
      repeat ($urandom_range(1, 6)) nm.push_back(pick_name_char(1'b1));
      return nm;
   endfunction

   task automatic send_item(logic kind, logic [7:0] ch, logic last);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_ch    <= ch;
      req_last  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      step_matcher(kind, ch, last);
      items_sent++;
   endtask

   task automatic send_run(logic kind, char_q_type cs);
      foreach (cs[i]) send_item(kind, cs[i], i == cs.size() - 1);
   endtask

   task automatic test_unloaded_pattern();
      char_q_type nm;
      nm.push_back(8'h00);
      nm.push_back(8'hFF);
      send_run(KIND_NAME, nm);
   endtask

   task automatic test_literals_and_wildcards();
      send_run(KIND_PATTERN, chars("a*?"));
      send_run(KIND_NAME, chars("a/"));
      send_run(KIND_NAME, chars("ab/"));
      send_run(KIND_NAME, chars("a/b"));
   endtask

   task automatic test_slash_in_pattern();
      send_run(KIND_PATTERN, chars("x/"));
      send_run(KIND_NAME, chars("x/"));
   endtask

   task automatic test_name_during_load();
      char_q_type nm;
      send_run(KIND_PATTERN, chars("*"));
      send_item(KIND_PATTERN, CH_QUESTION, 1'b0);
      send_run(KIND_NAME, chars("zz"));
      send_item(KIND_PATTERN, 8'hFF, 1'b1);
      nm.push_back(8'h41);
      nm.push_back(8'hFF);
      send_run(KIND_NAME, nm);
   endtask

   task automatic test_store_limits();
      char_q_type pat;
      repeat (STORE_DEPTH - 1) pat.push_back(CH_STAR);
      pat.push_back("z");
      send_run(KIND_PATTERN, pat);
      send_run(KIND_NAME, chars("z"));
      send_run(KIND_NAME, chars("abz"));
      pat.delete();
      repeat (STORE_DEPTH + 1) pat.push_back("a");
      send_run(KIND_PATTERN, pat);
      send_run(KIND_NAME, chars("a"));
      pat[STORE_DEPTH] = CH_SLASH;
      send_run(KIND_PATTERN, pat);
      send_run(KIND_NAME, chars("a"));
   endtask

   task automatic test_random_traffic();
      char_q_type pat;
      int         stop_at;
      int         len;
      int         cut;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         calm = ($urandom_range(0, 3) == 0);
         pat.delete();
         len = ($urandom_range(0, 49) == 0) ? $urandom_range(240, 260) : $urandom_range(1, 8);
         repeat (len) pat.push_back(pick_pattern_char(1'b1));
         cut = ($urandom_range(0, 9) == 0 && len > 1) ? $urandom_range(1, len - 1) : 0;
         foreach (pat[i]) begin
            if (cut != 0 && i == cut) send_run(KIND_NAME, random_name());
            send_item(KIND_PATTERN, pat[i], i == len - 1);
         end
         repeat (len > 8 ? 1 : $urandom_range(1, 6)) begin
            if ($urandom_range(0, 9) < 7) send_run(KIND_NAME, derive_name(pat));
            else send_run(KIND_NAME, random_name());
         end
      end
      calm = 1'b0;
   endtask

   initial begin : drain_results
      int gap;
      wait (!reset);
      @(posedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_results
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_q.size() == 0) begin
            $display("%0t: unexpected result kind %0d matched %0d status %0d", $time,
                     rsp_result_kind, rsp_matched, rsp_pattern_status);
            errors++;
         end else begin
            want = verdict_q.pop_front();
            if (rsp_result_kind !== want.result_kind) begin
               $display("%0t: result_kind expected %0d actual %0d", $time,
                        want.result_kind, rsp_result_kind);
               errors++;
            end
            if (rsp_matched !== want.matched) begin
               $display("%0t: matched expected %0d actual %0d", $time,
                        want.matched, rsp_matched);
               errors++;
            end
            if (rsp_pattern_status !== want.status) begin
               $display("%0t: pattern_status expected %0d actual %0d", $time,
                        want.status, rsp_pattern_status);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("wildcard_name_matcher verification failed");
         $finish;
      end
   end

   initial begin
      pat_len   = 0;
      load_ptr  = 0;
      pat_fault = STATUS_OK;
      restart_positions();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unloaded_pattern();
      test_literals_and_wildcards();
      test_slash_in_pattern();
      test_name_during_load();
      test_store_limits();
      test_random_traffic();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && verdict_q.size() == 0) begin
         $display("wildcard_name_matcher verification clean");
      end else begin
         $display("wildcard_name_matcher verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/wnm_pkg.sv
rtl/wnm_pattern_store.sv
rtl/wnm_position_set.sv
rtl/wildcard_name_matcher.sv
tb/wildcard_name_matcher_tb.sv
